// ----- rtl/mh64a_pkg.sv -----
`default_nettype none
package mh64a_pkg;

  localparam logic [63:0] MIX_MUL = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_WORD,
    S_K1,
    S_K2,
    S_HMUL,
    S_FIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  function automatic logic [63:0] xorshift(input logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/murmurhash64a_hash.sv -----
// Each 64-bit product is computed on one shared 32x32 multiplier
// (three partial products plus accumulate), and a full word needs three of them;
// the first word of a message also needs the length product, and the last word
// the finish product and the output load. A zero-length item goes to the output load.
// Throughput: one item at a time; in_stall is high while an item is in work.
// Reset (rst, synchronous): sequencer idle, no message open, no result held.
`default_nettype none
module murmurhash64a_hash #(
  parameter int LENGTH_BITS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [63:0] data_word,
  input  wire  [31:0] total_length,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [63:0] hash_value
);
  import mh64a_pkg::*;

  localparam int EFF_BITS = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
  localparam int CNT_W    = EFF_BITS - 2;

  state_t            state;
  state_t            state_next;
  mul_req_t          req;
  mul_rsp_t          rsp;
  logic [63:0]       hash_acc;
  logic [63:0]       word_reg;
  logic [63:0]       result;
  logic [CNT_W-1:0]  words_remaining;
  logic [2:0]        tail_byte_count;
  logic              in_message;

  logic              accept;
  logic              out_free;
  logic [EFF_BITS-1:0] len_eff;
  logic [CNT_W-1:0]  words_new;
  logic              tail_word;
  logic              last_word;
  logic [63:0]       keep;

  mh64a_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    accept    = in_valid && !in_stall;
    out_free  = !out_valid || !out_stall;
    len_eff   = total_length[EFF_BITS-1:0];
    words_new = CNT_W'(len_eff[EFF_BITS-1:3]) + CNT_W'(|len_eff[2:0]);
    last_word = (words_remaining == CNT_W'(1));
    tail_word = last_word && (tail_byte_count != 3'd0);
    keep      = (64'd1 << {tail_byte_count, 3'b000}) - 64'd1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_message) begin
            state_next = S_WORD;
          end else if (words_new == '0) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_LEN;
          end
        end
      end
      S_LEN:  if (rsp.done) state_next = S_WORD;
      S_WORD: state_next = tail_word ? S_HMUL : S_K1;
      S_K1:   if (rsp.done) state_next = S_K2;
      S_K2:   if (rsp.done) state_next = S_HMUL;
      S_HMUL: if (rsp.done) state_next = last_word ? S_FIN : S_IDLE;
      S_FIN:  if (rsp.done) state_next = S_EMIT;
      S_EMIT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (state != S_IDLE);
    req.start   = 1'b0;
    req.operand = 64'd0;
    unique case (state) inside
      S_IDLE: begin
        if (in_valid && !in_message && words_new != '0) begin
          req.start   = 1'b1;
          req.operand = 64'(len_eff);
        end
      end
      S_WORD: begin
        req.start   = 1'b1;
        req.operand = tail_word ? (hash_acc ^ (word_reg & keep)) : word_reg;
      end
      S_K1: begin
        req.start   = rsp.done;
        req.operand = xorshift(rsp.product);
      end
      S_K2: begin
        req.start   = rsp.done;
        req.operand = hash_acc ^ rsp.product;
      end
      S_HMUL: begin
        req.start   = rsp.done && last_word;
        req.operand = xorshift(rsp.product);
      end
      S_LEN, S_FIN, S_EMIT: begin
        req.start   = 1'b0;
        req.operand = 64'd0;
      end
      default: begin
        req.start   = 1'b0;
        req.operand = 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      in_message      <= 1'b0;
      words_remaining <= '0;
      tail_byte_count <= 3'd0;
      hash_acc        <= 64'd0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end
      if (accept && !in_message) begin
        tail_byte_count <= len_eff[2:0];
        words_remaining <= words_new;
        in_message      <= (words_new != '0);
      end
      if (state == S_LEN && rsp.done) begin
        hash_acc <= rsp.product;
      end
      if (state == S_HMUL && rsp.done) begin
        hash_acc        <= rsp.product;
        words_remaining <= words_remaining - CNT_W'(1);
      end
      if (state == S_FIN && rsp.done) begin
        hash_acc        <= 64'd0;
        tail_byte_count <= 3'd0;
        in_message      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_reg <= data_word;
    end
    if (accept && !in_message) begin
      result <= 64'd0;
    end
    if (state == S_FIN && rsp.done) begin
      result <= xorshift(rsp.product);
    end
    if (state == S_EMIT && out_free) begin
      hash_value <= result;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_LEN || state == S_K1 || state == S_K2 ||
                  state == S_HMUL || state == S_FIN))
    else $error("multiplier finished outside a wait state");

  a_open_msg_count: assert property (@(posedge clk) disable iff (rst)
    (in_message && state == S_IDLE) |-> (words_remaining != '0))
    else $error("open message with no words left");

  a_close_to_emit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(in_message)) |-> (state == S_EMIT))
    else $error("message closed without a result");

endmodule
`default_nettype wire

// ----- rtl/mh64a_mul.sv -----
`default_nettype none
module mh64a_mul (
  input  wire                  clk,
  input  wire                  rst,
  input  mh64a_pkg::mul_req_t  req,
  output mh64a_pkg::mul_rsp_t  rsp
);
  import mh64a_pkg::*;

  logic        busy;
  logic        done;
  logic [1:0]  phase;
  logic [63:0] operand;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  always_comb begin
    mul_a = (phase == 2'd2) ? operand[63:32] : operand[31:0];
    mul_b = (phase == 2'd1) ? MIX_MUL[63:32] : MIX_MUL[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      operand <= req.operand;
    end
    prod <= 64'(mul_a) * 64'(mul_b);
    if (busy) begin
      case (phase) inside
        2'd1: acc <= prod;
        2'd2, 2'd3: acc[63:32] <= acc[63:32] + prod[31:0];
        default: acc <= acc;
      endcase
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule
`default_nettype wire
